### rtl/qoi8_pkg.sv
package qoi8_pkg;

   localparam int unsigned INDEX_DEPTH = 64;
   localparam int unsigned INDEX_AW    = 6;
   localparam int unsigned COUNT_W     = 17;
   localparam int unsigned RUN_W       = 6;

   localparam logic [7:0] TAG_LITERAL  = 8'hFF;
   localparam logic [1:0] TAG_RUN      = 2'b11;
   localparam logic [1:0] TAG_INDEX    = 2'b10;
   localparam logic [7:0] DIFF_BIAS    = 8'd128;

   localparam logic [COUNT_W-1:0] COUNT_MAX         = 17'd131071;
   localparam logic [COUNT_W-1:0] PIXEL_LIMIT_RESET = 17'd76800;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       chunk_start;
   } qoi8_req_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       pixel_last;
      logic       limit_reached;
   } qoi8_rsp_type;

   // write and clear requests towards the colour index
   typedef struct packed {
      logic                wr_en;
      logic [INDEX_AW-1:0] wr_addr;
      logic [7:0]          wr_data;
      logic                clear;
   } qoi8_idx_ctl_type;

endpackage

### rtl/qoi_style_8bit_pixel_decoder.sv
// Decoder for a QOI-like stream of 8-bit indexed pixels. One encoded byte is
// taken per cycle unless the input is held; literal payloads, diff and index
// bytes give one pixel each, while a run tag gives (low six bits + 1) pixels,
// one a cycle through the single output register, holding the input until
// its last pixel. A stalled output holds the input too. A byte is registered
// in the input register, its pixel in the output register. The 64-entry
// colour index is a small memory with a registered read issued as the byte is
// taken; a write by the byte ahead is forwarded, and per-entry valid bits make
// reset and frame start clear it at once, so no clearing pass is needed.
// The pixel limit may only be written while the block is idle.
module qoi_style_8bit_pixel_decoder (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  qoi8_pkg::qoi8_req_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output qoi8_pkg::qoi8_rsp_type        rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [qoi8_pkg::COUNT_W-1:0]  csr_data
);
   import qoi8_pkg::*;

   // input register, holding the byte under decode
   logic                item_valid_ff, item_valid_in;
   qoi8_req_type        item_ff;
   // decoder state
   logic [7:0]          prev_ff, prev_in;
   logic                lit_ff, lit_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                stopped_ff, stopped_in;
   logic [COUNT_W-1:0]  max_ff;
   logic [RUN_W-1:0]    k_ff, k_in;
   logic                lim_ff, lim_in;
   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   qoi8_rsp_type        rsp_ff, rsp_in;

   logic                accept;
   logic                out_free;
   logic                produces;
   logic                first;
   logic                last;
   logic                emit;
   logic                item_done;
   logic                commit;
   logic [7:0]          b;
   logic [7:0]          idx_data;
   logic [7:0]          pix_new;
   logic [RUN_W:0]      n;
   logic                is_run;
   logic                eff_stopped;
   logic [COUNT_W-1:0]  eff_count;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  count_new;
   logic                lim_new;
   qoi8_idx_ctl_type    idx_ctl;

   assign b        = item_ff.data_byte;
   assign first    = (k_ff == '0);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // chunk start takes effect before the byte is decoded; a run already under
   // way finishes even if its first pixel stopped the chunk
   assign eff_count   = item_ff.chunk_start ? '0 : count_ff;
   assign eff_stopped = (item_ff.chunk_start || !first) ? 1'b0 : stopped_ff;

   assign is_run = !lit_ff && (b != TAG_LITERAL) && (b[7:6] == TAG_RUN);

   always_comb begin
      pix_new  = prev_ff;
      produces = 1'b1;
      n        = {{RUN_W{1'b0}}, 1'b1};
      if (item_ff.req_type || eff_stopped) begin
         produces = 1'b0;
      end else if (lit_ff) begin
         pix_new = b;
      end else if (b == TAG_LITERAL) begin
         produces = 1'b0;
      end else if (b[7:6] == TAG_RUN) begin
         n = {1'b0, b[RUN_W-1:0]} + {{RUN_W{1'b0}}, 1'b1};
      end else if (b[7] == 1'b0) begin
         // small diff steps down, large diff steps up
         if (b[6] == 1'b0) begin
            pix_new = prev_ff - {2'b00, b[5:0]} - 8'd1;
         end else begin
            pix_new = prev_ff + (DIFF_BIAS - {1'b0, b[6:0]});
         end
      end else begin
         pix_new = idx_data;
      end
   end

   // chunk count with saturation
   assign sum       = {1'b0, eff_count} + {{(COUNT_W-RUN_W){1'b0}}, n};
   assign count_new = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
   assign lim_new   = (count_new >= max_ff);

   assign last      = is_run ? (k_ff == b[RUN_W-1:0]) : 1'b1;
   assign emit      = item_valid_ff && produces && out_free;
   assign item_done = item_valid_ff && (!produces || (out_free && last));
   assign commit    = item_valid_ff && first && (produces ? out_free : 1'b1);

   assign req_stall = item_valid_ff && !item_done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      idx_ctl.clear   = commit && item_ff.req_type;
      idx_ctl.wr_en   = commit && produces && !is_run && (lit_ff || b[7] == 1'b0);
      idx_ctl.wr_addr = pix_new[INDEX_AW-1:0];
      idx_ctl.wr_data = pix_new;
   end

   qoi8_index u_index (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_data.data_byte[INDEX_AW-1:0]),
      .ctl     (idx_ctl),
      .rd_data (idx_data)
   );

   // state moves on the first pixel of an item, or at once when it has none
   always_comb begin
      prev_in    = prev_ff;
      lit_in     = lit_ff;
      count_in   = count_ff;
      stopped_in = stopped_ff;
      lim_in     = lim_ff;
      if (commit) begin
         if (item_ff.req_type) begin
            prev_in = 8'd0;
            lit_in  = 1'b0;
         end else begin
            count_in   = eff_count;
            stopped_in = eff_stopped;
            if (!eff_stopped) begin
               if (produces) begin
                  prev_in    = pix_new;
                  lit_in     = 1'b0;
                  count_in   = count_new;
                  stopped_in = lim_new;
                  lim_in     = lim_new;
               end else begin
                  // literal tag: payload follows
                  lit_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      k_in = k_ff;
      if (item_done) begin
         k_in = '0;
      end else if (emit) begin
         k_in = k_ff + {{(RUN_W-1){1'b0}}, 1'b1};
      end
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (accept) begin
         item_valid_in = 1'b1;
      end else if (item_done) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_in               = rsp_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_in.pixel         = first ? pix_new : prev_ff;
         rsp_in.pixel_last    = last;
         rsp_in.limit_reached = first ? lim_new : lim_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         prev_ff       <= 8'd0;
         lit_ff        <= 1'b0;
         count_ff      <= '0;
         stopped_ff    <= 1'b0;
         max_ff        <= PIXEL_LIMIT_RESET;
         k_ff          <= '0;
         lim_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         prev_ff       <= prev_in;
         lit_ff        <= lit_in;
         count_ff      <= count_in;
         stopped_ff    <= stopped_in;
         k_ff          <= k_in;
         lim_ff        <= lim_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid) begin
            max_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_data;
      end
      rsp_ff <= rsp_in;
   end

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/qoi8_index.sv
module qoi8_index (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [qoi8_pkg::INDEX_AW-1:0]  rd_addr,
   input  qoi8_pkg::qoi8_idx_ctl_type     ctl,
   output logic [7:0]                     rd_data
);
   import qoi8_pkg::*;

   logic [7:0]             mem [INDEX_DEPTH];
   logic [INDEX_DEPTH-1:0] valid_ff;
   logic [INDEX_DEPTH-1:0] valid_in;
   logic [7:0]             mem_rd_ff;
   logic                   fwd_ff;
   logic [7:0]             fwd_data_ff;
   logic                   hit_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         // same-edge write wins over the stored entry
         fwd_ff      <= ctl.wr_en && (ctl.wr_addr == rd_addr);
         fwd_data_ff <= ctl.wr_data;
         hit_ff      <= valid_ff[rd_addr] && !ctl.clear;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = fwd_ff ? fwd_data_ff : (hit_ff ? mem_rd_ff : 8'd0);

endmodule

### bench/qoi8_checker.sv
`timescale 1ns / 1ps
module qoi8_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  qoi8_pkg::qoi8_req_type       req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  qoi8_pkg::qoi8_rsp_type       rsp_data,
   input  logic                         csr_valid,
   input  logic                         csr_ready,
   input  logic [qoi8_pkg::COUNT_W-1:0] csr_data,
   output int                           fail_count,
   output int                           pending_results
);
   import qoi8_pkg::*;

   logic [7:0]         palette [INDEX_DEPTH];
   logic [7:0]         last_pixel;
   logic               literal_next;
   logic [COUNT_W-1:0] pixels_in_chunk;
   logic               chunk_done;
   logic [COUNT_W-1:0] pixel_limit;
   qoi8_rsp_type       expected_pixels [$];

   initial fail_count = 0;
   initial pending_results = 0;

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= 100) begin
         $display("mismatch at %0t ns: %s", $time, what);
      end
   endtask

   task automatic clear_palette();
      foreach (palette[i]) begin
         palette[i] = '0;
      end
      last_pixel   = '0;
      literal_next = 1'b0;
   endtask

   // works out the pixels that one accepted item gives
   task automatic decode_byte(input qoi8_req_type item);
      int unsigned  n;
      int unsigned  total;
      logic [6:0]   delta;
      logic         at_limit;
      qoi8_rsp_type pix;
      if (item.req_type) begin
         clear_palette();
         return;
      end
      if (item.chunk_start) begin
         pixels_in_chunk = '0;
         chunk_done      = 1'b0;
      end
      if (chunk_done) return;
      if (literal_next) begin
         literal_next = 1'b0;
         last_pixel   = item.data_byte;
         palette[last_pixel[5:0]] = last_pixel;
         n = 1;
      end else if (item.data_byte == TAG_LITERAL) begin
         literal_next = 1'b1;
         return;
      end else if (item.data_byte[7:6] == TAG_RUN) begin
         n = int'(item.data_byte[5:0]) + 1;
      end else if (item.data_byte[7:6] == TAG_INDEX) begin
         last_pixel = palette[item.data_byte[5:0]];
         n = 1;
      end else begin
         delta = item.data_byte[6:0];
         if (delta <= 7'd63) begin
            last_pixel = last_pixel - 8'(delta) - 8'd1;
         end else begin
            last_pixel = last_pixel + (DIFF_BIAS - 8'(delta));
         end
         palette[last_pixel[5:0]] = last_pixel;
         n = 1;
      end
      total = int'(pixels_in_chunk) + n;
      if (total > int'(COUNT_MAX)) total = int'(COUNT_MAX);
      pixels_in_chunk = total[COUNT_W-1:0];
      at_limit = (pixels_in_chunk >= pixel_limit);
      if (at_limit) chunk_done = 1'b1;
      for (int k = 0; k < int'(n); k++) begin
         pix.pixel         = last_pixel;
         pix.pixel_last    = (k == int'(n) - 1);
         pix.limit_reached = at_limit;
         expected_pixels.push_back(pix);
      end
   endtask

   task automatic check_pixel(input qoi8_rsp_type got);
      qoi8_rsp_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch($sformatf("unexpected pixel %h last %b limit %b",
                                   got.pixel, got.pixel_last, got.limit_reached));
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel !== want.pixel || got.pixel_last !== want.pixel_last ||
          got.limit_reached !== want.limit_reached) begin
         report_mismatch($sformatf("pixel %h last %b limit %b, wanted %h %b %b",
                                   got.pixel, got.pixel_last, got.limit_reached,
                                   want.pixel, want.pixel_last, want.limit_reached));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_palette();
         pixels_in_chunk = '0;
         chunk_done      = 1'b0;
         pixel_limit     = PIXEL_LIMIT_RESET;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) pixel_limit = csr_data;
         if (rsp_valid && !rsp_stall) check_pixel(rsp_data);
         if (req_valid && !req_stall) decode_byte(req_data);
      end
      pending_results <= expected_pixels.size();
   end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import qoi8_pkg::*;

   localparam int HOLD_CYCLES = 200;

   logic               clock;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   qoi8_req_type       req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   qoi8_rsp_type       rsp_data;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [COUNT_W-1:0] csr_data  = '0;

   int fail_count;
   int pending_results;

   // sender state: items left in the current burst, whether valid is up,
   // and whether bursts are switched off for a back-to-back stream
   int burst_left       = 0;
   bit offering         = 1'b0;
   bit steady           = 1'b0;
   bit hold_off_request = 1'b0;

   qoi_style_8bit_pixel_decoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   qoi8_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #50_000_000;
      $display("testbench failed");
      $finish;
   end

   // receiver: stretches of no stalling, light, medium and heavy stalling,
   // plus one long hold-off on request so the decoder backs up into its input
   initial begin : receiver
      int mode;
      int span;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(4, 64);
         repeat (span) begin
            @(posedge clock);
            if (hold_off_request) begin
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_off_request = 1'b0;
            end
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   function automatic qoi8_req_type make_item(input logic frame, input logic [7:0] value,
                                              input logic first);
      qoi8_req_type item;
      item.req_type    = frame;
      item.data_byte   = value;
      item.chunk_start = first;
      return item;
   endfunction

   // offer one item and hold it until taken; the burst gap, if any, follows
   // straight after acceptance so valid is only ever assigned once per edge
   task automatic send_item(input qoi8_req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      offering  = 1'b1;
      do @(posedge clock); while (req_stall);
      if (!steady && burst_left == 0) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 8);
      end else if (burst_left > 0) begin
         burst_left--;
      end
   endtask

   task automatic send_byte(input logic [7:0] value, input logic first = 1'b0);
      send_item(make_item(1'b0, value, first));
   endtask

   task automatic send_frame(input logic [7:0] value, input logic first);
      send_item(make_item(1'b1, value, first));
   endtask

   // drop valid, let every expected pixel drain, then allow for bytes that
   // give no pixel but may still be in flight
   task automatic settle();
      if (offering) begin
         req_valid <= 1'b0;
         offering  = 1'b0;
      end
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_pixel_limit(input logic [COUNT_W-1:0] value);
      settle();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // well-formed chunks with random content, with a sprinkling of frame
   // starts, stray chunk starts and raw noise bytes
   task automatic random_phase(input int count);
      int   sent;
      int   pick;
      logic first;
      sent  = 0;
      first = 1'b1;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4) begin
            send_frame(8'($urandom), 1'($urandom));
            sent++;
         end else if (pick < 10) begin
            first = 1'b1;
         end else if (pick < 40) begin
            send_byte({1'b0, 7'($urandom)}, first);
            first = 1'b0;
            sent++;
         end else if (pick < 58) begin
            send_byte({TAG_INDEX, 6'($urandom_range(0, 63))}, first);
            first = 1'b0;
            sent++;
         end else if (pick < 73) begin
            send_byte(TAG_LITERAL, first);
            send_byte(8'($urandom));
            first = 1'b0;
            sent += 2;
         end else if (pick < 88) begin
            // mostly short runs, now and then a long one (low bits all ones is the literal tag)
            if ($urandom_range(0, 9) == 0) begin
               send_byte({TAG_RUN, 6'($urandom_range(0, 62))}, first);
            end else begin
               send_byte({TAG_RUN, 6'($urandom_range(0, 7))}, first);
            end
            first = 1'b0;
            sent++;
         end else begin
            send_byte(8'($urandom), 1'($urandom));
            first = 1'b0;
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, limit at its reset value
      send_frame(8'hA5, 1'b1);          // frame start with the other fields set
      send_byte(8'h00, 1'b1);           // smallest backward diff
      send_byte(8'h3F);                 // largest backward diff
      send_byte(8'h40);                 // largest forward diff
      send_byte(8'h7F);                 // smallest forward diff
      send_byte(TAG_LITERAL);
      send_byte(8'h00);                 // literal payload of zero
      send_byte(TAG_LITERAL);
      send_byte(8'hFF);                 // literal payload that looks like the tag
      send_byte(8'hC0);                 // run of one
      send_byte(8'hFE);                 // longest run
      send_byte(8'h80);                 // index entry zero
      send_byte(8'hBF);                 // index entry 63
      send_byte(8'h95);
      send_byte(TAG_LITERAL);           // literal tag closing the chunk
      send_byte(8'h5A, 1'b1);           // payload carried into the new chunk
      send_byte(TAG_LITERAL);
      send_frame(8'h00, 1'b0);          // frame start drops the pending literal
      send_byte(8'h12);
      send_byte(8'hAD);                 // entry written by the diff above
      send_byte(8'h81);                 // entry wiped by the frame start

      // zero limit: first pixel-giving byte still decodes, then the chunk stops
      set_pixel_limit('0);
      send_byte(8'h05, 1'b1);
      send_byte(8'h10);                 // ignored
      send_byte(8'hC5, 1'b1);           // whole run comes out, then stop
      send_byte(TAG_LITERAL, 1'b1);     // no limit check on the tag itself
      send_byte(8'h33);

      // small limit crossed part way through a run
      set_pixel_limit(17'd3);
      send_byte(8'h01, 1'b1);
      send_byte(8'hC4);
      send_byte(8'h02);                 // ignored
      send_byte(8'h02, 1'b1);

      // random phases over a range of limits
      set_pixel_limit(PIXEL_LIMIT_RESET);
      random_phase(90);
      set_pixel_limit(17'd1);
      random_phase(60);
      set_pixel_limit(17'd12);
      random_phase(70);
      set_pixel_limit(17'($urandom_range(2, 200)));
      random_phase(70);
      set_pixel_limit('0);
      random_phase(30);
      set_pixel_limit(COUNT_MAX);
      random_phase(80);

      // back pressure: receiver holds off while runs keep coming back to back
      settle();
      hold_off_request = 1'b1;
      steady = 1'b1;
      send_byte(8'hC7, 1'b1);
      repeat (40) begin
         send_byte({TAG_RUN, 6'($urandom_range(0, 15))});
      end
      steady = 1'b0;

      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule

### qoi_style_8bit_pixel_decoder.f
rtl/qoi8_pkg.sv
rtl/qoi8_index.sv
rtl/qoi_style_8bit_pixel_decoder.sv
bench/qoi8_checker.sv
bench/testbench.sv
